// ===== rtl/cpr_pkg.sv =====
// Shared constants and types for the clock page replacement block.
package cpr_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int PAGE_WIDTH = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int ENTRY_W    = PAGE_WIDTH + 1;   // {dirty, page}
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic REG_SLOTS_IN_USE = 1'b0;     // register index, paddr[2]

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_VREAD,
    ST_FIN
  } cpr_state_t;

endpackage

// ===== rtl/cpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/clock_page_replacement.sv =====
// Top level: second-chance clock page replacement over a RAM of frame slots.
// A hit in slot i ends the lookup scan at slot i; a fault that fills a free slot scans all n
// active slots first; an eviction scans them, then takes s sweep steps (1 <= s <= n+1) and
// a victim read, n = active slot count. Lookup scans one RAM entry per cycle.
// One request at a time; the next request is taken the cycle after the result enters the
// output register.
// Reset (synchronous, rst_n low) clears valid/reference marks, hand, fill count and sets
// slots_in_use to 16; the page RAM needs no clearing pass.
module clock_page_replacement
  import cpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PAGE_WIDTH-1:0] in_page_number,
  input  logic                  in_is_write,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_fault,
  output logic [3:0]            out_slot_index,
  output logic                  out_evicted,
  output logic [15:0]           out_victim_page,
  output logic                  out_victim_dirty,
  // APB-style configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  // ---------------------------------------------------------------- registers
  cpr_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       slots_r, slots_nxt;      // raw slots_in_use register
  logic [SLOT_COUNT-1:0]  valid_r, valid_nxt;
  logic [SLOT_COUNT-1:0]  ref_r, ref_nxt;
  logic [SLOT_W-1:0]      hand_r, hand_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;          // lookup scan position
  logic [SLOT_W-1:0]      victim_r, victim_nxt;
  logic [PAGE_WIDTH-1:0]  page_r, page_nxt;        // request being served
  logic                   wr_r, wr_nxt;

  // result held until the output register frees up
  logic                   res_fault_r, res_fault_nxt;
  logic [SLOT_W-1:0]      res_slot_r, res_slot_nxt;
  logic                   res_ev_r, res_ev_nxt;
  logic [PAGE_WIDTH-1:0]  res_vpage_r, res_vpage_nxt;
  logic                   res_vdirty_r, res_vdirty_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_fault_r, out_fault_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                   out_ev_r, out_ev_nxt;
  logic [PAGE_WIDTH-1:0]  out_vpage_r, out_vpage_nxt;
  logic                   out_vdirty_r, out_vdirty_nxt;

  // ---------------------------------------------------------------- page RAM
  // Each entry is {dirty, page}; only read behind a set valid bit.
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;

  cpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [PAGE_WIDTH-1:0]  rd_page;
  logic                   rd_dirty;
  assign rd_page  = ram_rdata[PAGE_WIDTH-1:0];
  assign rd_dirty = ram_rdata[PAGE_WIDTH];

  // ---------------------------------------------------------------- decode
  // Active slot count: zero acts as one, oversize clamps to SLOT_COUNT.
  logic [CNT_W-1:0]       n_act;
  always_comb begin
    priority if (slots_r == '0) begin
      n_act = CNT_W'(1);
    end else if (slots_r > CNT_W'(SLOT_COUNT)) begin
      n_act = CNT_W'(SLOT_COUNT);
    end else begin
      n_act = slots_r;
    end
  end

  logic look_hit, look_last, have_free, out_free;
  logic [CNT_W-1:0] hand_inc;
  logic [SLOT_W-1:0] hand_adv;

  assign look_hit  = valid_r[idx_r] && (rd_page == page_r);
  assign look_last = ({1'b0, idx_r} == n_act - CNT_W'(1));
  assign have_free = (fill_r < n_act);
  assign out_free  = !out_valid_r || out_ready;
  assign hand_inc  = {1'b0, hand_r} + CNT_W'(1);
  assign hand_adv  = (hand_inc == n_act) ? '0 : hand_inc[SLOT_W-1:0];

  // ---------------------------------------------------------------- config port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? DATA_W'(slots_r) : '0;

  always_comb begin
    slots_nxt = slots_r;
    if (cfg_wr && paddr[2] == REG_SLOTS_IN_USE) begin
      slots_nxt = pwdata[CNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        priority if (look_hit) begin
          state_nxt = ST_FIN;
        end else if (look_last) begin
          state_nxt = have_free ? ST_FIN : ST_SWEEP;
        end else begin
          state_nxt = ST_LOOK;
        end
      end
      ST_SWEEP: begin
        if (!ref_r[hand_r]) state_nxt = ST_VREAD;
      end
      ST_VREAD: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    valid_nxt      = valid_r;
    ref_nxt        = ref_r;
    hand_nxt       = hand_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    victim_nxt     = victim_r;
    page_nxt       = page_r;
    wr_nxt         = wr_r;
    res_fault_nxt  = res_fault_r;
    res_slot_nxt   = res_slot_r;
    res_ev_nxt     = res_ev_r;
    res_vpage_nxt  = res_vpage_r;
    res_vdirty_nxt = res_vdirty_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_fault_nxt  = out_fault_r;
    out_slot_nxt   = out_slot_r;
    out_ev_nxt     = out_ev_r;
    out_vpage_nxt  = out_vpage_r;
    out_vdirty_nxt = out_vdirty_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = {wr_r, page_r};
    ram_raddr      = '0;
    in_ready       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = '0;            // first lookup entry
        if (in_valid) begin
          page_nxt = in_page_number;
          wr_nxt   = in_is_write;
          idx_nxt  = '0;
        end
      end
      ST_LOOK: begin
        ram_raddr = idx_r + SLOT_W'(1);   // prefetch next entry
        priority if (look_hit) begin
          // hit: mark referenced, OR in the write flag
          ram_we         = 1'b1;
          ram_waddr      = idx_r;
          ram_wdata      = {rd_dirty | wr_r, page_r};
          ref_nxt[idx_r] = 1'b1;
          res_fault_nxt  = 1'b0;
          res_slot_nxt   = idx_r;
          res_ev_nxt     = 1'b0;
          res_vpage_nxt  = '0;
          res_vdirty_nxt = 1'b0;
        end else if (look_last) begin
          res_fault_nxt  = 1'b1;
          res_ev_nxt     = 1'b0;
          res_vpage_nxt  = '0;
          res_vdirty_nxt = 1'b0;
          if (have_free) begin
            ram_we                       = 1'b1;
            ram_waddr                    = fill_r[SLOT_W-1:0];
            valid_nxt[fill_r[SLOT_W-1:0]] = 1'b1;
            ref_nxt[fill_r[SLOT_W-1:0]]   = 1'b1;
            res_slot_nxt                 = fill_r[SLOT_W-1:0];
            fill_nxt                     = fill_r + CNT_W'(1);
          end else begin
            // hand left beyond a shrunk slot count restarts at slot 0
            hand_nxt = ({1'b0, hand_r} >= n_act) ? '0 : hand_r;
          end
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_SWEEP: begin
        ram_raddr = hand_r;
        hand_nxt  = hand_adv;
        if (!ref_r[hand_r]) begin
          victim_nxt = hand_r;
        end else begin
          ref_nxt[hand_r] = 1'b0;   // second chance
        end
      end
      ST_VREAD: begin
        ram_we              = 1'b1;
        ram_waddr           = victim_r;
        ram_wdata           = {wr_r, page_r};
        valid_nxt[victim_r] = 1'b1;
        ref_nxt[victim_r]   = 1'b1;
        res_slot_nxt        = victim_r;
        res_ev_nxt          = valid_r[victim_r];
        res_vpage_nxt       = valid_r[victim_r] ? rd_page : '0;
        res_vdirty_nxt      = valid_r[victim_r] && rd_dirty;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_fault_nxt  = res_fault_r;
          out_slot_nxt   = res_slot_r;
          out_ev_nxt     = res_ev_r;
          out_vpage_nxt  = res_vpage_r;
          out_vdirty_nxt = res_vdirty_r;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slots_r     <= CNT_W'(SLOT_COUNT);
      valid_r     <= '0;
      ref_r       <= '0;
      hand_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slots_r     <= slots_nxt;
      valid_r     <= valid_nxt;
      ref_r       <= ref_nxt;
      hand_r      <= hand_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    victim_r     <= victim_nxt;
    page_r       <= page_nxt;
    wr_r         <= wr_nxt;
    res_fault_r  <= res_fault_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ev_r     <= res_ev_nxt;
    res_vpage_r  <= res_vpage_nxt;
    res_vdirty_r <= res_vdirty_nxt;
    out_fault_r  <= out_fault_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ev_r     <= out_ev_nxt;
    out_vpage_r  <= out_vpage_nxt;
    out_vdirty_r <= out_vdirty_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_fault        = out_fault_r;
  assign out_slot_index   = out_slot_r;
  assign out_evicted      = out_ev_r;
  assign out_victim_page  = out_vpage_r;
  assign out_victim_dirty = out_vdirty_r;

  // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(SLOT_COUNT))
    else $error("fill count beyond slot count");

  a_sweep_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !have_free)
    else $error("victim sweep with a free slot left");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fault_r || !out_ev_r))
    else $error("hit reported an eviction");

  a_installed_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VREAD) |=> valid_r[$past(victim_r)] && ref_r[$past(victim_r)])
    else $error("installed slot not valid and referenced");
`endif

endmodule
